### design/bap_pkg.sv
package bap_pkg;

  localparam int NAME_MAX = 31;
  localparam int MFG_MAX  = 31;
  localparam int STORE_DEPTH = 31;

  localparam logic [7:0] AD_FLAGS      = 8'h01;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;
  localparam logic [7:0] AD_MAKER      = 8'hFF;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_MAKER   = 2'd2;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } bap_phase_t;

  typedef enum logic [1:0] {
    SK_OTHER = 2'd0,
    SK_NAME  = 2'd1,
    SK_MAKER = 2'd2,
    SK_FLAGS = 2'd3
  } bap_skind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } bap_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       name_found;
    logic [4:0] name_length;
    logic       maker_found;
    logic [4:0] maker_length;
    logic       final_result;
  } bap_out_t;

  typedef struct packed {
    logic take;
    logic sum_load;
    logic fetch;
    logic load;
    logic clear;
  } bap_cmd_t;

  typedef struct packed {
    logic last;
  } bap_sts_t;

endpackage

### design/bap_dpath.sv
module bap_dpath
  import bap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bap_cmd_t   cmd,
  input  logic [7:0] data_byte,
  output bap_sts_t   sts,
  output bap_out_t   out_data
);

  bap_phase_t phase_r, phase_nxt;
  bap_skind_t skind_r, skind_nxt;
  logic [7:0] left_r, left_nxt;
  logic [4:0] name_cnt_r, name_cnt_nxt;
  logic       name_vld_r, name_vld_nxt;
  logic [4:0] mkr_cnt_r, mkr_cnt_nxt;
  logic       mkr_vld_r, mkr_vld_nxt;
  logic [7:0] flags_r, flags_nxt;
  logic [8:0] pend_r, pend_nxt;
  logic       name_we, mkr_we;
  logic       finish;

  logic [7:0] name_mem [STORE_DEPTH];
  logic [7:0] mkr_mem  [STORE_DEPTH];
  logic [7:0] name_rd_r, mkr_rd_r;
  logic       is_name_r;
  logic [5:0] rd_k_r;
  bap_out_t   out_r;

  logic [4:0] nlen, mlen;
  logic [5:0] tail_cnt;
  logic [5:0] mkr_off;

  assign nlen     = name_vld_r ? name_cnt_r : 5'd0;
  assign mlen     = mkr_vld_r ? mkr_cnt_r : 5'd0;
  assign tail_cnt = {1'b0, nlen} + {1'b0, mlen};
  assign mkr_off  = rd_k_r - {1'b0, nlen};

  // Parse one payload byte
  always_comb begin
    phase_nxt    = phase_r;
    skind_nxt    = skind_r;
    left_nxt     = left_r;
    name_cnt_nxt = name_cnt_r;
    name_vld_nxt = name_vld_r;
    mkr_cnt_nxt  = mkr_cnt_r;
    mkr_vld_nxt  = mkr_vld_r;
    flags_nxt    = flags_r;
    pend_nxt     = pend_r;
    name_we      = 1'b0;
    mkr_we       = 1'b0;
    finish       = 1'b0;
    if (cmd.clear) begin
      phase_nxt    = PH_LEN;
      skind_nxt    = SK_OTHER;
      left_nxt     = 8'd0;
      name_cnt_nxt = 5'd0;
      name_vld_nxt = 1'b0;
      mkr_cnt_nxt  = 5'd0;
      mkr_vld_nxt  = 1'b0;
      pend_nxt     = 9'd0;
    end else if (cmd.take) begin
      unique case (phase_r)
        PH_LEN: begin
          if (data_byte == 8'd0) begin
            phase_nxt = PH_DONE;
          end else begin
            left_nxt  = data_byte - 8'd1;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          skind_nxt = SK_OTHER;
          if ((data_byte == AD_NAME_SHORT || data_byte == AD_NAME_FULL) && !name_vld_r) begin
            skind_nxt    = SK_NAME;
            name_cnt_nxt = 5'd0;
          end else if (data_byte == AD_MAKER && !mkr_vld_r) begin
            skind_nxt   = SK_MAKER;
            mkr_cnt_nxt = 5'd0;
          end else if (data_byte == AD_FLAGS) begin
            skind_nxt = SK_FLAGS;
            pend_nxt  = 9'd0;
          end
          if (left_r == 8'd0) begin
            finish = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          unique case (skind_r)
            SK_NAME: begin
              if (name_cnt_r < 5'(NAME_MAX)) begin
                name_we      = 1'b1;
                name_cnt_nxt = name_cnt_r + 5'd1;
              end
            end
            SK_MAKER: begin
              if (mkr_cnt_r < 5'(MFG_MAX)) begin
                mkr_we      = 1'b1;
                mkr_cnt_nxt = mkr_cnt_r + 5'd1;
              end
            end
            SK_FLAGS: begin
              if (!pend_r[8]) begin
                pend_nxt = {1'b1, data_byte};
              end
            end
            SK_OTHER: begin
            end
            default: begin
            end
          endcase
          left_nxt = left_r - 8'd1;
          if (left_nxt == 8'd0) begin
            finish = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
      // Close the structure using the kind and flags chosen this cycle
      if (finish) begin
        if (skind_nxt == SK_NAME) begin
          name_vld_nxt = 1'b1;
        end else if (skind_nxt == SK_MAKER) begin
          mkr_vld_nxt = 1'b1;
        end else if (skind_nxt == SK_FLAGS && pend_nxt[8]) begin
          flags_nxt = pend_nxt[7:0];
        end
        skind_nxt = SK_OTHER;
        phase_nxt = PH_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEN;
      skind_r    <= SK_OTHER;
      left_r     <= 8'd0;
      name_cnt_r <= 5'd0;
      name_vld_r <= 1'b0;
      mkr_cnt_r  <= 5'd0;
      mkr_vld_r  <= 1'b0;
      flags_r    <= 8'd0;
      pend_r     <= 9'd0;
      rd_k_r     <= 6'd0;
    end else begin
      phase_r    <= phase_nxt;
      skind_r    <= skind_nxt;
      left_r     <= left_nxt;
      name_cnt_r <= name_cnt_nxt;
      name_vld_r <= name_vld_nxt;
      mkr_cnt_r  <= mkr_cnt_nxt;
      mkr_vld_r  <= mkr_vld_nxt;
      flags_r    <= flags_nxt;
      pend_r     <= pend_nxt;
      if (cmd.sum_load) begin
        rd_k_r <= 6'd0;
      end else if (cmd.load) begin
        rd_k_r <= rd_k_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[name_cnt_r] <= data_byte;
    end
    if (mkr_we) begin
      mkr_mem[mkr_cnt_r] <= data_byte;
    end
    if (cmd.fetch) begin
      name_rd_r <= name_mem[rd_k_r[4:0]];
      mkr_rd_r  <= mkr_mem[mkr_off[4:0]];
      is_name_r <= (rd_k_r < {1'b0, nlen});
    end
  end

  // Result register: summary first, then stored bytes
  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      out_r.kind         <= KIND_SUMMARY;
      out_r.value        <= flags_r;
      out_r.name_found   <= name_vld_r;
      out_r.name_length  <= nlen;
      out_r.maker_found  <= mkr_vld_r;
      out_r.maker_length <= mlen;
      out_r.final_result <= (tail_cnt == 6'd0);
    end else if (cmd.load) begin
      out_r.kind         <= is_name_r ? KIND_NAME : KIND_MAKER;
      out_r.value        <= is_name_r ? name_rd_r : mkr_rd_r;
      out_r.final_result <= ((rd_k_r + 6'd1) == tail_cnt);
    end
  end

  assign out_data = out_r;
  assign sts.last = out_r.final_result;

endmodule

### design/bap_ctrl.sv
module bap_ctrl
  import bap_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_eop,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  bap_sts_t sts,
  output bap_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_SEND  = 5'b00100,
    S_FETCH = 5'b01000,
    S_LOAD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_eop) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          state_nxt = sts.last ? S_IDLE : S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_SEND;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_SEND);
  assign cmd.take     = (state_r == S_IDLE) && in_valid;
  assign cmd.sum_load = (state_r == S_SUM);
  assign cmd.fetch    = (state_r == S_FETCH);
  assign cmd.load     = (state_r == S_LOAD);
  assign cmd.clear    = (state_r == S_SEND) && out_ready && sts.last;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result channels active together");

  a_eop_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_eop |=> state_r == S_SUM)
    else $error("end of payload did not start readout");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && sts.last |=> in_ready && !out_valid)
    else $error("last item did not return to input");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> out_valid && out_ready && sts.last)
    else $error("payload state cleared outside final item");

endmodule

### design/ble_adv_structure_parser.sv
// BLE advertising structure parser.
// Input channel (in_valid/in_ready/in_data): one payload byte per item, with
// end_of_payload set on the last byte. Each byte is parsed in the cycle it is
// accepted; in_ready stays high while no readout is running, so bytes that
// do not end a payload are taken one per cycle.
// Result channel (out_valid/out_ready/out_data): after the final byte the
// block emits a summary item (flags byte, name and manufacturer status and
// lengths), then the captured name bytes, then the manufacturer bytes; the
// last item has final_result set.
// After the final byte is taken, the controller passes through S_SUM, which
// loads the summary into the result register, and then presents it in S_SEND.
// Each further item passes through the handshake in S_SEND, the registered
// store read in S_FETCH and the load of the result register in S_LOAD. The
// input stays held for the whole readout, including any receiver stall.
// While out_ready is low the result register holds its item and no input is
// taken. After the final item the per-payload state clears and in_ready
// returns the next cycle; the flags byte persists across payloads.
// Reset (rst_n low, synchronous) returns to the length-byte phase with
// flags zero and nothing captured; store contents are not cleared.
module ble_adv_structure_parser
  import bap_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bap_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bap_out_t out_data
);

  bap_cmd_t cmd;
  bap_sts_t sts;

  bap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_eop    (in_data.end_of_payload),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bap_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_data.data_byte),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
